// ===== rtl/set_assoc_cache_lru_fifo_assert.svh =====
// ---------------------------------------------------------------------------
// set_assoc_cache_lru_fifo assertion macros
// shared property wrappers, clocked on clk and disabled in reset
// ---------------------------------------------------------------------------
`ifndef SET_ASSOC_CACHE_LRU_FIFO_ASSERT_SVH
`define SET_ASSOC_CACHE_LRU_FIFO_ASSERT_SVH

// same-cycle implication
`define SACL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SACL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/sacl_pkg.sv =====
// ---------------------------------------------------------------------------
// sacl_pkg
// geometry constants, line and row types, register codes and the
// command and status bundles between controller and datapath
// ---------------------------------------------------------------------------
package sacl_pkg;

  localparam int ADDR_W     = 32;
  localparam int SETS       = 64;
  localparam int WAYS       = 8;
  localparam int STAMP_W    = 32;
  localparam int CNT_W      = 32;
  localparam int SET_W      = $clog2(SETS);
  localparam int WAY_W      = $clog2(WAYS);
  localparam int TAG_W      = ADDR_W;
  localparam int SB_W       = 3;
  localparam int OB_W       = 5;
  localparam int WB_W       = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;
  localparam int OUT_WAY_W  = 3;
  localparam int PAIRS      = (WAYS + 1) / 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SET_BITS    = 2'd0,
    CFG_OFFSET_BITS = 2'd1,
    CFG_WAY_BITS    = 2'd2,
    CFG_USE_FIFO    = 2'd3
  } sacl_cfg_idx_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EVAL,
    ST_COMMIT
  } sacl_state_t;

  typedef struct packed {
    logic               valid;
    logic [TAG_W-1:0]   tag;
    logic [STAMP_W-1:0] stamp;
  } sacl_line_t;

  typedef sacl_line_t [WAYS-1:0] sacl_row_t;

  typedef struct packed {
    logic clr;
    logic capture;
    logic eval;
    logic commit;
  } sacl_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic out_free;
  } sacl_sts_t;

endpackage

// ===== rtl/set_assoc_cache_lru_fifo.sv =====
// ---------------------------------------------------------------------------
// set_assoc_cache_lru_fifo
// After reset the block sweeps its 64-set tag store, one set per cycle, and
// holds in_stall high throughout the sweep (config writes are still taken).
// Each address then goes through these steps: read the set, compare the
// 8 ways and reduce stamp pairs, then pick the victim, write the set back
// and load the result register. The set read is registered and the stamp
// reduction is two-stage. A finished result waits in its own register
// while the next address is looked up; the next write-back waits until
// that result is taken. Counters saturate; set_bits above 6 acts as 6.
// ---------------------------------------------------------------------------
`include "set_assoc_cache_lru_fifo_assert.svh"

module set_assoc_cache_lru_fifo (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [sacl_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sacl_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [sacl_pkg::ADDR_W-1:0]      in_address,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             out_hit,
  output logic [sacl_pkg::OUT_WAY_W-1:0]   out_way_used,
  output logic [sacl_pkg::CNT_W-1:0]       out_hit_total,
  output logic [sacl_pkg::CNT_W-1:0]       out_miss_total
);

  sacl_pkg::sacl_cmd_t cmd;
  sacl_pkg::sacl_sts_t sts;
  logic                cfg_wr;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid & cfg_ready;

  sacl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  sacl_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .cfg_wr         (cfg_wr),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_address     (in_address),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_hit        (out_hit),
    .out_way_used   (out_way_used),
    .out_hit_total  (out_hit_total),
    .out_miss_total (out_miss_total)
  );

  // result register never overwritten while held
  `SACL_ASSERT_NOW(a_no_overwrite, cmd.commit, !out_valid || !out_stall, "result overwritten")

  // one item in flight
  `SACL_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "accepted while busy")

  // a taken result is not shown again
  `SACL_ASSERT_NEXT(a_no_repeat, out_valid && !out_stall && !cmd.commit, !out_valid,
                    "result repeated")

  // store sweep and lookup never overlap
  `SACL_ASSERT_NOW(a_clr_excl, cmd.clr, !cmd.capture && !cmd.commit && in_stall,
                   "clear overlaps lookup")

endmodule

// ===== rtl/sacl_ctrl.sv =====
// ---------------------------------------------------------------------------
// sacl_ctrl
// sequencer: clearing pass, accept, evaluate, commit
// ---------------------------------------------------------------------------
module sacl_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  sacl_pkg::sacl_sts_t sts,
  output sacl_pkg::sacl_cmd_t cmd
);

  sacl_pkg::sacl_state_t state_r;
  sacl_pkg::sacl_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sacl_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sacl_pkg::ST_CLEAR: begin
        if (sts.clr_last) state_nxt = sacl_pkg::ST_IDLE;
      end
      sacl_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = sacl_pkg::ST_EVAL;
      end
      sacl_pkg::ST_EVAL: begin
        state_nxt = sacl_pkg::ST_COMMIT;
      end
      sacl_pkg::ST_COMMIT: begin
        if (sts.out_free) state_nxt = sacl_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = sacl_pkg::ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      sacl_pkg::ST_CLEAR: begin
        cmd.clr = 1'b1;
      end
      sacl_pkg::ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
      end
      sacl_pkg::ST_EVAL: begin
        cmd.eval = 1'b1;
      end
      sacl_pkg::ST_COMMIT: begin
        cmd.commit = sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// ===== rtl/sacl_dp.sv =====
// ---------------------------------------------------------------------------
// sacl_dp
// set store, config registers, tag compare, victim choice, counters
// and result register
// ---------------------------------------------------------------------------
module sacl_dp (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  sacl_pkg::sacl_cmd_t                  cmd,
  output sacl_pkg::sacl_sts_t                  sts,
  input  logic                                 cfg_wr,
  input  logic [sacl_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [sacl_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic [sacl_pkg::ADDR_W-1:0]          in_address,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 out_hit,
  output logic [sacl_pkg::OUT_WAY_W-1:0]       out_way_used,
  output logic [sacl_pkg::CNT_W-1:0]           out_hit_total,
  output logic [sacl_pkg::CNT_W-1:0]           out_miss_total
);

  localparam int SW = sacl_pkg::SET_W;
  localparam int WW = sacl_pkg::WAY_W;
  localparam int NW = sacl_pkg::WAYS;
  localparam int NP = sacl_pkg::PAIRS;
  localparam int TW = sacl_pkg::STAMP_W;

  // config registers
  logic [sacl_pkg::SB_W-1:0] set_bits_r;
  logic [sacl_pkg::OB_W-1:0] offset_bits_r;
  logic [sacl_pkg::WB_W-1:0] way_bits_r;
  logic                      use_fifo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_bits_r    <= '0;
      offset_bits_r <= '0;
      way_bits_r    <= '0;
      use_fifo_r    <= 1'b0;
    end else if (cfg_wr) begin
      case (sacl_pkg::sacl_cfg_idx_t'(cfg_index))
        sacl_pkg::CFG_SET_BITS:    set_bits_r    <= cfg_data[sacl_pkg::SB_W-1:0];
        sacl_pkg::CFG_OFFSET_BITS: offset_bits_r <= cfg_data[sacl_pkg::OB_W-1:0];
        sacl_pkg::CFG_WAY_BITS:    way_bits_r    <= cfg_data[sacl_pkg::WB_W-1:0];
        sacl_pkg::CFG_USE_FIFO:    use_fifo_r    <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // address split
  logic [sacl_pkg::SB_W-1:0]   sb_eff;
  logic [WW:0]                 wb_eff;
  logic [sacl_pkg::ADDR_W-1:0] addr_sh;
  logic [SW:0]                 set_mask;
  logic [SW-1:0]               rd_idx;
  logic [6:0]                  tag_shift;
  logic [sacl_pkg::TAG_W-1:0]  tag_in;

  always_comb begin
    sb_eff = (set_bits_r > sacl_pkg::SB_W'(SW)) ? sacl_pkg::SB_W'(SW) : set_bits_r;
    wb_eff = ((WW+1)'(way_bits_r) > (WW+1)'(WW)) ? (WW+1)'(WW) : (WW+1)'(way_bits_r);
    addr_sh   = in_address >> offset_bits_r;
    set_mask  = ((SW+1)'(1) << sb_eff) - (SW+1)'(1);
    rd_idx    = addr_sh[SW-1:0] & set_mask[SW-1:0];
    tag_shift = 7'(offset_bits_r) + 7'(sb_eff);
    tag_in    = sacl_pkg::TAG_W'(in_address >> tag_shift);
  end

  // set store
  sacl_pkg::sacl_row_t        mem [sacl_pkg::SETS];
  sacl_pkg::sacl_row_t        rd_row_r;
  sacl_pkg::sacl_row_t        row_upd;
  logic [SW-1:0]              set_r;
  logic [sacl_pkg::TAG_W-1:0] tag_r;
  logic [SW-1:0]              clr_idx_r;
  logic                       wr_en;
  logic [SW-1:0]              wr_idx;
  sacl_pkg::sacl_row_t        wr_row;

  assign wr_en  = cmd.clr | cmd.commit;
  assign wr_idx = cmd.clr ? clr_idx_r : set_r;
  assign wr_row = cmd.clr ? sacl_pkg::sacl_row_t'('0) : row_upd;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_idx] <= wr_row;
    if (cmd.capture) rd_row_r <= mem[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      set_r <= rd_idx;
      tag_r <= tag_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_idx_r <= '0;
    end else if (cmd.clr) begin
      clr_idx_r <= clr_idx_r + SW'(1);
    end
  end

  // lookup and first min stage
  logic [NW-1:0] active;
  logic [NW-1:0] hitv;
  logic [NW-1:0] invv;
  logic          hit_c;
  logic [WW-1:0] hit_way_c;
  logic          inv_c;
  logic [WW-1:0] inv_way_c;
  logic [TW-1:0] s1_stamp_c [NP];
  logic [WW-1:0] s1_way_c   [NP];
  logic [NP-1:0] s1_cand_c;

  always_comb begin
    hit_c     = 1'b0;
    hit_way_c = '0;
    inv_c     = 1'b0;
    inv_way_c = '0;
    for (int w = 0; w < NW; w++) begin
      active[w] = ((WW+1)'(w) >> wb_eff) == '0;
      hitv[w]   = active[w] & rd_row_r[w].valid & (rd_row_r[w].tag == tag_r);
      invv[w]   = active[w] & ~rd_row_r[w].valid;
    end
    for (int w = NW - 1; w >= 0; w--) begin
      if (hitv[w]) begin
        hit_c     = 1'b1;
        hit_way_c = WW'(w);
      end
      if (invv[w]) begin
        inv_c     = 1'b1;
        inv_way_c = WW'(w);
      end
    end
    for (int k = 0; k < NP; k++) begin
      s1_stamp_c[k] = rd_row_r[2*k].stamp;
      s1_way_c[k]   = WW'(2*k);
      s1_cand_c[k]  = active[2*k];
      if (2*k + 1 < NW) begin
        if (active[2*k+1] && (rd_row_r[2*k+1].stamp < rd_row_r[2*k].stamp)) begin
          s1_stamp_c[k] = rd_row_r[2*k+1].stamp;
          s1_way_c[k]   = WW'(2*k + 1);
        end
      end
    end
  end

  logic          hit_r;
  logic [WW-1:0] hit_way_r;
  logic          inv_r;
  logic [WW-1:0] inv_way_r;
  logic [TW-1:0] s1_stamp_r [NP];
  logic [WW-1:0] s1_way_r   [NP];
  logic [NP-1:0] s1_cand_r;

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      hit_r     <= hit_c;
      hit_way_r <= hit_way_c;
      inv_r     <= inv_c;
      inv_way_r <= inv_way_c;
      s1_cand_r <= s1_cand_c;
      for (int k = 0; k < NP; k++) begin
        s1_stamp_r[k] <= s1_stamp_c[k];
        s1_way_r[k]   <= s1_way_c[k];
      end
    end
  end

  // victim choice and row update
  logic [TW-1:0]          best_stamp;
  logic [WW-1:0]          best_way;
  logic [WW-1:0]          way_sel;
  logic [TW-1:0]          time_r;
  logic [TW-1:0]          time_nxt;
  logic [sacl_pkg::CNT_W-1:0] hit_cnt_r;
  logic [sacl_pkg::CNT_W-1:0] hit_cnt_nxt;
  logic [sacl_pkg::CNT_W-1:0] miss_cnt_r;
  logic [sacl_pkg::CNT_W-1:0] miss_cnt_nxt;

  always_comb begin
    best_stamp = s1_stamp_r[0];
    best_way   = s1_way_r[0];
    for (int k = 1; k < NP; k++) begin
      if (s1_cand_r[k] && (s1_stamp_r[k] < best_stamp)) begin
        best_stamp = s1_stamp_r[k];
        best_way   = s1_way_r[k];
      end
    end
    time_nxt = (time_r == '1) ? time_r : time_r + TW'(1);
    way_sel  = hit_r ? hit_way_r : (inv_r ? inv_way_r : best_way);
    row_upd  = rd_row_r;
    if (hit_r) begin
      if (!use_fifo_r) row_upd[way_sel].stamp = time_nxt;
    end else begin
      row_upd[way_sel].valid = 1'b1;
      row_upd[way_sel].tag   = tag_r;
      row_upd[way_sel].stamp = time_nxt;
    end
    hit_cnt_nxt  = hit_cnt_r;
    miss_cnt_nxt = miss_cnt_r;
    if (hit_r) begin
      if (hit_cnt_r != '1) hit_cnt_nxt = hit_cnt_r + sacl_pkg::CNT_W'(1);
    end else begin
      if (miss_cnt_r != '1) miss_cnt_nxt = miss_cnt_r + sacl_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_r     <= '0;
      hit_cnt_r  <= '0;
      miss_cnt_r <= '0;
    end else if (cmd.commit) begin
      time_r     <= time_nxt;
      hit_cnt_r  <= hit_cnt_nxt;
      miss_cnt_r <= miss_cnt_nxt;
    end
  end

  // result register
  logic out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_hit        <= hit_r;
      out_way_used   <= sacl_pkg::OUT_WAY_W'(way_sel);
      out_hit_total  <= hit_cnt_nxt;
      out_miss_total <= miss_cnt_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign sts.out_free = ~out_valid_r | ~out_stall;
  assign sts.clr_last = (clr_idx_r == SW'(sacl_pkg::SETS - 1));

endmodule
